// ===== design/mfd_pkg.sv =====
// shared types and helpers for the minifloat to double converter
// no dependencies
package mfd_pkg;

  localparam int unsigned SigWidth = 53;

  localparam logic [1:0] CfgTotalWidth = 2'd0;
  localparam logic [1:0] CfgExpWidth   = 2'd1;
  localparam logic [1:0] CfgManWidth   = 2'd2;

  typedef struct packed {
    logic [6:0] total_width;
    logic [3:0] exp_width;
    logic [5:0] man_width;
  } cfg_t;

  typedef struct packed {
    logic        sign;
    logic        bad;
    logic [10:0] efield;
    logic [51:0] mfield;
  } unpack_t;

  typedef struct packed {
    logic               sign;
    logic               bad;
    logic               zero;
    logic [52:0]        sig;
    logic signed [12:0] e2;
    logic [5:0]         msb;
  } norm_t;

  function automatic logic [63:0] low_mask(input logic [6:0] w);
    logic [63:0] m;
    if (w >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << w) - 64'd1;
    end
    return m;
  endfunction

endpackage

// ===== design/mfd_unpack.sv =====
// stage 1: config check and field extraction from the raw word
// depends on mfd_pkg
module mfd_unpack import mfd_pkg::*; #(
  parameter int unsigned RAW_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [RAW_WIDTH-1:0] raw_i,
  input  cfg_t                 cfg_i,
  output logic                 vld_o,
  output unpack_t              data_o
);

  logic        vld_q;
  unpack_t     data_q, data_d;
  logic [63:0] raw;
  logic [6:0]  sh_e, sh_m;
  logic [7:0]  used;

  always_comb begin
    raw  = 64'(raw_i) & low_mask(cfg_i.total_width);
    used = 8'(cfg_i.exp_width) + 8'(cfg_i.man_width) + 8'd1;
    sh_e = cfg_i.total_width - 7'd1 - 7'(cfg_i.exp_width);
    sh_m = sh_e - 7'(cfg_i.man_width);
    data_d.bad = (cfg_i.exp_width < 4'd2) || (cfg_i.exp_width > 4'd11) ||
                 (cfg_i.man_width < 6'd1) || (cfg_i.man_width > 6'd52) ||
                 (32'(cfg_i.total_width) > RAW_WIDTH) ||
                 (used > 8'(cfg_i.total_width));
    data_d.sign   = raw[6'(cfg_i.total_width - 7'd1)];
    data_d.efield = 11'((raw >> sh_e) & low_mask(7'(cfg_i.exp_width)));
    data_d.mfield = 52'((raw >> sh_m) & low_mask(7'(cfg_i.man_width)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== design/mfd_norm.sv =====
// stage 2: significand, unbiased exponent and leading one position
// depends on mfd_pkg
module mfd_norm import mfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    vld_i,
  input  unpack_t data_i,
  input  cfg_t    cfg_i,
  output logic    vld_o,
  output norm_t   data_o
);

  logic        vld_q;
  norm_t       data_q, data_d;
  logic [12:0] bias;

  always_comb begin
    bias = (13'd1 << (cfg_i.exp_width - 4'd1)) - 13'd1;
    data_d.sign = data_i.sign;
    data_d.bad  = data_i.bad;
    data_d.zero = (data_i.efield == 11'd0) && (data_i.mfield == 52'd0);
    if (data_i.efield == 11'd0) begin
      data_d.sig = {1'b0, data_i.mfield};
      data_d.e2  = 13'sd1 - $signed(bias);
    end else begin
      data_d.sig = (53'd1 << cfg_i.man_width) | {1'b0, data_i.mfield};
      data_d.e2  = $signed({2'b00, data_i.efield}) - $signed(bias);
    end
    // leading one search, highest set bit wins
    data_d.msb = 6'd0;
    for (int i = 0; i < SigWidth; i++) begin
      if (data_d.sig[i]) begin
        data_d.msb = 6'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule

// ===== design/mfd_pack.sv =====
// stage 3: double exponent, range checks and binary64 assembly
// depends on mfd_pkg
module mfd_pack import mfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  norm_t       data_i,
  input  cfg_t        cfg_i,
  output logic        vld_o,
  output logic [63:0] bits_o,
  output logic        ovf_o,
  output logic        bad_o
);

  logic               vld_q;
  logic [63:0]        bits_q, bits_d;
  logic               ovf_q, ovf_d, bad_q;
  logic signed [12:0] dexp, sub_sh;
  logic [52:0]        shifted;

  always_comb begin
    dexp   = data_i.e2 - $signed({7'd0, cfg_i.man_width}) + $signed({7'd0, data_i.msb});
    sub_sh = data_i.e2 - $signed({7'd0, cfg_i.man_width}) + 13'sd1074;
    bits_d = {data_i.sign, 63'd0};
    ovf_d  = 1'b0;
    shifted = '0;
    if (data_i.bad) begin
      bits_d = '0;
    end else if (data_i.zero) begin
      bits_d = {data_i.sign, 63'd0};
    end else if (dexp > 13'sd1023) begin
      bits_d = {data_i.sign, 11'h7ff, 52'd0};
      ovf_d  = 1'b1;
    end else if (dexp >= -13'sd1022) begin
      shifted = data_i.sig << (6'd52 - data_i.msb);
      bits_d  = {data_i.sign, 11'(dexp + 13'sd1023), shifted[51:0]};
    end else begin
      // double subnormal
      if (sub_sh >= 13'sd0 && sub_sh < 13'sd64) begin
        shifted = data_i.sig << sub_sh[5:0];
      end
      bits_d = {data_i.sign, 11'd0, shifted[51:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bits_q <= bits_d;
      ovf_q  <= ovf_d;
      bad_q  <= data_i.bad;
    end
  end

  assign vld_o  = vld_q;
  assign bits_o = bits_q;
  assign ovf_o  = ovf_q;
  assign bad_o  = bad_q;

endmodule

// ===== design/minifloat_to_double_converter_unit.sv =====
// top level of the minifloat to double converter, config registers and stall control
// depends on mfd_pkg, mfd_unpack, mfd_norm, mfd_pack
// Converts a custom-width float (sign, exp_width exponent bits, man_width fraction
// bits in the low total_width bits of raw_bits_i) to its IEEE binary64 pattern.
// Three register stages: field extraction, significand and leading-one search, then
// exponent range check and packing. One request is taken every cycle unless the pipe
// is stalled. The whole pipe advances together and holds when a result waits on
// out_ready_i. Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i and
// must only change while the pipe is empty.
module minifloat_to_double_converter_unit import mfd_pkg::*; #(
  parameter int unsigned RAW_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [6:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [RAW_WIDTH-1:0] raw_bits_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [63:0]          double_bits_o,
  output logic                 overflowed_o,
  output logic                 bad_config_o
);

  cfg_t    cfg_q;
  logic    en;
  logic    v1, v2;
  unpack_t d1;
  norm_t   d2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.total_width <= 7'd32;
      cfg_q.exp_width   <= 4'd8;
      cfg_q.man_width   <= 6'd23;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTotalWidth: cfg_q.total_width <= cfg_wdata_i;
        CfgExpWidth:   cfg_q.exp_width   <= cfg_wdata_i[3:0];
        CfgManWidth:   cfg_q.man_width   <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  mfd_unpack #(.RAW_WIDTH(RAW_WIDTH)) u_unpack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .raw_i  (raw_bits_i),
    .cfg_i  (cfg_q),
    .vld_o  (v1),
    .data_o (d1)
  );

  mfd_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v1),
    .data_i (d1),
    .cfg_i  (cfg_q),
    .vld_o  (v2),
    .data_o (d2)
  );

  mfd_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v2),
    .data_i (d2),
    .cfg_i  (cfg_q),
    .vld_o  (out_valid_o),
    .bits_o (double_bits_o),
    .ovf_o  (overflowed_o),
    .bad_o  (bad_config_o)
  );

  a_ovf_inf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o |-> double_bits_o[62:0] == {11'h7ff, 52'd0} && !bad_config_o)
    else $error("overflow without infinity");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_config_o |-> double_bits_o == 64'd0 && !overflowed_o)
    else $error("bad config with nonzero result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2 && out_valid_o && !out_ready_i |=> v2)
    else $error("item lost in stalled pipe");

endmodule
